>>> rtl/core/idfd_pkg.sv
// Shared types, codes and helper functions for the image frame deframer.
package idfd_pkg;

    localparam int DefLengthBits = 32;
    localparam int FifoDepth     = 4;
    localparam int FifoAw        = $clog2(FifoDepth);

    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

    // result kinds on the output ports
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_MATCH    = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_ARM,
        CMD_END
    } cmd_kind_t;

    // request from the line parser to the CRC/output side
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] frame;
        logic [31:0] crc;     // expected CRC on CMD_ARM
    } cmd_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
        end
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (is_dec(c))
            v = c - "0";
        else if ((c >= "a") && (c <= "f"))
            v = c - "a" + 8'd10;
        else
            v = c - "A" + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] json_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = "J";
            3'd1:    r = "S";
            3'd2:    r = "O";
            3'd3:    r = "N";
            default: r = " ";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] image_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = "I";
            3'd1:    r = "M";
            3'd2:    r = "A";
            3'd3:    r = "G";
            3'd4:    r = "E";
            default: r = " ";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] end_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = "E";
            3'd1:    r = "N";
            default: r = "D";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h22;
            3'd1:    r = "f";
            3'd2:    r = "r";
            3'd3:    r = "a";
            3'd4:    r = "m";
            3'd5:    r = "e";
            3'd6:    r = 8'h22;
            default: r = ":";
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/image_frame_deframer_crc_check.sv
// Top level of the image frame deframer with payload CRC-32 check.
//
//   port group     direction  handshake         payload
//   received byte  in         push / full       rx_byte
//   result item    out        pop / empty       kind, data_byte, last_payload,
//                                               frame_number, computed_crc
//
// One byte per cycle is accepted while full is low; the parser handles each byte in
// the cycle it is taken. A result passes through the request queue and then the
// output register. full rises when the four-entry request queue fills, i.e. after
// the output side has stalled for several results. Reset is asynchronous and
// needs no clearing pass.
module image_frame_deframer_crc_check #(
    parameter int LENGTH_BITS = idfd_pkg::DefLengthBits
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic        last_payload,
    output logic [31:0] frame_number,
    output logic [31:0] computed_crc
);
    import idfd_pkg::*;

    logic in_take;
    logic cmd_push, cmd_pop, q_full, q_empty;
    cmd_t cmd_in, cmd_out;

    assign in_take = push && !q_full;
    assign full    = q_full;

    idfd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .rx_byte  (rx_byte),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    idfd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .full    (q_full),
        .empty   (q_empty)
    );

    idfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (q_empty),
        .cmd          (cmd_out),
        .cmd_pop      (cmd_pop),
        .pop          (pop && !empty),
        .empty        (empty),
        .kind         (kind),
        .data_byte    (data_byte),
        .last_payload (last_payload),
        .frame_number (frame_number),
        .computed_crc (computed_crc)
    );

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_DATA) |-> (data_byte == 8'd0 && !last_payload))
        else $error("frame end result carries payload fields");

    a_data_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_DATA) |-> computed_crc == 32'd0)
        else $error("payload result carries a CRC");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(computed_crc)))
        else $error("waiting result changed");

endmodule

>>> rtl/core/idfd_front.sv
// Line parser: classifies received bytes, parses JSON/IMAGE/END lines, counts payload.
module idfd_front #(
    parameter int LENGTH_BITS = idfd_pkg::DefLengthBits
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_take,
    input  logic [7:0]     rx_byte,
    output logic           cmd_push,
    output idfd_pkg::cmd_t cmd
);
    import idfd_pkg::*;

    localparam int PnW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    typedef enum logic [1:0] {
        PH_WAIT_JSON,
        PH_WAIT_HEADER,
        PH_READ,
        PH_WAIT_END
    } phase_t;

    typedef enum logic [3:0] {
        NP_IDLE, NP_A_WS, NP_A_SIGN, NP_A_DIG,
        NP_B_WS, NP_B_SIGN, NP_B_ZERO, NP_B_X, NP_B_DIG, NP_DONE
    } np_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             pos_reg, pos_next;
    logic                   cj_reg, cj_next, ci_reg, ci_next, ce_reg, ce_next;
    logic                   tail_reg, tail_next;
    logic [3:0]             key_reg, key_next;
    np_t                    np_reg, np_next;
    logic                   negA_reg, negA_next, negB_reg, negB_next;
    logic [PnW-1:0]         pn_reg, pn_next;
    logic [31:0]            pcrc_reg, pcrc_next;
    logic [31:0]            frame_reg, frame_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;

    logic                   push_c;
    cmd_t                   cmd_c;

    always_comb
    begin
        logic [7:0]             c;
        logic                   ws;
        logic                   b_go;
        np_t                    nb;
        logic [PnW-1:0]         pnd;
        logic [LENGTH_BITS-1:0] need;
        logic [LENGTH_BITS:0]   cnt1;
        logic [PnW-1:0]         lenv;
        logic                   last;

        c     = rx_byte;
        ws    = is_ws(c);
        pnd   = (pn_reg << 3) + (pn_reg << 1) + PnW'(c - "0");
        need  = (len_reg == '0) ? LENGTH_BITS'(1) : len_reg;
        cnt1  = {1'b0, cnt_reg} + (LENGTH_BITS+1)'(1);
        last  = cnt1 >= {1'b0, need};
        lenv  = negA_reg ? (PnW'(0) - pn_reg) : pn_reg;
        b_go  = 1'b0;
        nb    = np_reg;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        cj_next    = cj_reg;
        ci_next    = ci_reg;
        ce_next    = ce_reg;
        tail_next  = tail_reg;
        key_next   = key_reg;
        np_next    = np_reg;
        negA_next  = negA_reg;
        negB_next  = negB_reg;
        pn_next    = pn_reg;
        pcrc_next  = pcrc_reg;
        frame_next = frame_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;

        push_c     = 1'b0;
        cmd_c.kind  = CMD_DATA;
        cmd_c.data  = c;
        cmd_c.last  = last;
        cmd_c.frame = frame_reg;
        cmd_c.crc   = pcrc_reg;

        if (phase_reg == PH_READ)
        begin
            push_c   = 1'b1;
            cnt_next = cnt1[LENGTH_BITS-1:0];
            if (last)
                phase_next = PH_WAIT_END;
        end
        else if (c != 8'h0A)
        begin
            if (!(pos_reg == 3'd0 && ws))
            begin
                if (pos_reg < 3'd5 && c != json_char(pos_reg))
                    cj_next = 1'b0;
                if (pos_reg < 3'd6 && c != image_char(pos_reg))
                    ci_next = 1'b0;
                if (pos_reg < 3'd3)
                begin
                    if (c != end_char(pos_reg))
                        ce_next = 1'b0;
                end
                else if (!ws)
                    ce_next = 1'b0;

                if (cj_next && pos_reg >= 3'd5)
                begin
                    if (!ws)
                        tail_next = 1'b1;
                    if (key_reg < 4'd8)
                    begin
                        if (c == key_char(key_reg[2:0]))
                            key_next = key_reg + 4'd1;
                        else
                            key_next = (c == 8'h22) ? 4'd1 : 4'd0;
                        if (key_next == 4'd8)
                            np_next = NP_A_WS;
                    end
                    else
                    begin
                        case (np_reg)
                            NP_A_WS:
                                if (!ws)
                                begin
                                    if (c == "+" || c == "-")
                                    begin
                                        negA_next = (c == "-");
                                        np_next   = NP_A_SIGN;
                                    end
                                    else if (is_dec(c))
                                    begin
                                        pn_next = PnW'(c - "0");
                                        np_next = NP_A_DIG;
                                    end
                                    else
                                        np_next = NP_DONE;
                                end
                            NP_A_SIGN:
                                if (is_dec(c))
                                begin
                                    pn_next = PnW'(c - "0");
                                    np_next = NP_A_DIG;
                                end
                                else
                                    np_next = NP_DONE;
                            NP_A_DIG:
                                if (is_dec(c))
                                    pn_next = pnd;
                                else
                                    np_next = NP_DONE;
                            default: ;
                        endcase
                    end
                end

                if (ci_next && pos_reg >= 3'd6)
                begin
                    if (!ws)
                        tail_next = 1'b1;
                    case (np_reg)
                        NP_A_WS:
                            if (!ws)
                            begin
                                if (c == "+" || c == "-")
                                begin
                                    negA_next = (c == "-");
                                    np_next   = NP_A_SIGN;
                                end
                                else if (is_dec(c))
                                begin
                                    pn_next = PnW'(c - "0");
                                    np_next = NP_A_DIG;
                                end
                                else
                                    np_next = NP_DONE;
                            end
                        NP_A_SIGN:
                            if (is_dec(c))
                            begin
                                pn_next = PnW'(c - "0");
                                np_next = NP_A_DIG;
                            end
                            else
                                np_next = NP_DONE;
                        NP_A_DIG:
                            if (is_dec(c))
                                pn_next = pnd;
                            else
                            begin
                                b_go = 1'b1;
                                nb   = NP_B_WS;
                            end
                        default:
                            b_go = 1'b1;
                    endcase
                    // second field: hex CRC
                    if (b_go)
                    begin
                        np_next = nb;
                        case (nb)
                            NP_B_WS:
                                if (!ws)
                                begin
                                    if (c == "+" || c == "-")
                                    begin
                                        negB_next = (c == "-");
                                        np_next   = NP_B_SIGN;
                                    end
                                    else if (c == "0")
                                        np_next = NP_B_ZERO;
                                    else if (is_hex(c))
                                    begin
                                        pcrc_next = {28'd0, hex_val(c)};
                                        np_next   = NP_B_DIG;
                                    end
                                    else
                                        np_next = NP_DONE;
                                end
                            NP_B_SIGN:
                                if (c == "0")
                                    np_next = NP_B_ZERO;
                                else if (is_hex(c))
                                begin
                                    pcrc_next = {28'd0, hex_val(c)};
                                    np_next   = NP_B_DIG;
                                end
                                else
                                    np_next = NP_DONE;
                            NP_B_ZERO:
                                if (c == "x" || c == "X")
                                    np_next = NP_B_X;
                                else if (is_hex(c))
                                begin
                                    pcrc_next = {28'd0, hex_val(c)};
                                    np_next   = NP_B_DIG;
                                end
                                else
                                    np_next = NP_DONE;
                            NP_B_X:
                                if (is_hex(c))
                                begin
                                    pcrc_next = {28'd0, hex_val(c)};
                                    np_next   = NP_B_DIG;
                                end
                                else
                                    np_next = NP_DONE;
                            NP_B_DIG:
                                if (is_hex(c))
                                    pcrc_next = {pcrc_reg[27:0], hex_val(c)};
                                else
                                    np_next = NP_DONE;
                            default: ;
                        endcase
                    end
                end

                if (ci_next && pos_reg == 3'd5)
                    np_next = NP_A_WS;
                if (pos_reg < 3'd7)
                    pos_next = pos_reg + 3'd1;
            end
        end
        else
        begin
            // end of line
            if (cj_reg && tail_reg)
            begin
                phase_next = PH_WAIT_HEADER;
                len_next   = '0;
                cnt_next   = '0;
                if (key_reg == 4'd8)
                    frame_next = negA_reg ? (32'd0 - pn_reg[31:0]) : pn_reg[31:0];
            end
            else if (phase_reg == PH_WAIT_HEADER && ci_reg && tail_reg)
            begin
                len_next    = lenv[LENGTH_BITS-1:0];
                cnt_next    = '0;
                phase_next  = PH_READ;
                push_c      = 1'b1;
                cmd_c.kind  = CMD_ARM;
                cmd_c.crc   = negB_reg ? (32'd0 - pcrc_reg) : pcrc_reg;
            end
            else if (phase_reg == PH_WAIT_END && ce_reg && pos_reg >= 3'd3)
            begin
                push_c     = 1'b1;
                cmd_c.kind = CMD_END;
                phase_next = PH_WAIT_JSON;
                len_next   = '0;
                cnt_next   = '0;
            end
            pos_next  = 3'd0;
            cj_next   = 1'b1;
            ci_next   = 1'b1;
            ce_next   = 1'b1;
            tail_next = 1'b0;
            key_next  = 4'd0;
            np_next   = NP_IDLE;
            negA_next = 1'b0;
            negB_next = 1'b0;
            pn_next   = '0;
            pcrc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_JSON;
            pos_reg   <= 3'd0;
            cj_reg    <= 1'b1;
            ci_reg    <= 1'b1;
            ce_reg    <= 1'b1;
            tail_reg  <= 1'b0;
            key_reg   <= 4'd0;
            np_reg    <= NP_IDLE;
            negA_reg  <= 1'b0;
            negB_reg  <= 1'b0;
            pn_reg    <= '0;
            pcrc_reg  <= '0;
            frame_reg <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (in_take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cj_reg    <= cj_next;
            ci_reg    <= ci_next;
            ce_reg    <= ce_next;
            tail_reg  <= tail_next;
            key_reg   <= key_next;
            np_reg    <= np_next;
            negA_reg  <= negA_next;
            negB_reg  <= negB_next;
            pn_reg    <= pn_next;
            pcrc_reg  <= pcrc_next;
            frame_reg <= frame_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cmd_push = in_take && push_c;
    assign cmd      = cmd_c;

endmodule

>>> rtl/core/idfd_fifo.sv
// Short request queue between the line parser and the CRC/output side.
module idfd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  idfd_pkg::cmd_t wr_data,
    input  logic           rd_en,
    output idfd_pkg::cmd_t rd_data,
    output logic           full,
    output logic           empty
);
    import idfd_pkg::*;

    cmd_t               mem [FifoDepth];
    logic [FifoAw-1:0]  wp_reg, rp_reg;
    logic [FifoAw:0]    cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + FifoAw'(1);
            if (rd_en)
                rp_reg <= rp_reg + FifoAw'(1);
            cnt_reg <= cnt_reg + (FifoAw+1)'(wr_en) - (FifoAw+1)'(rd_en);
        end
    end

    assign rd_data = mem[rp_reg];
    assign full    = cnt_reg == (FifoAw+1)'(FifoDepth);
    assign empty   = cnt_reg == '0;

endmodule

>>> rtl/core/idfd_back.sv
// CRC engine and result register: runs the payload CRC and builds result items.
module idfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  idfd_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           pop,
    output logic           empty,
    output logic [1:0]     kind,
    output logic [7:0]     data_byte,
    output logic           last_payload,
    output logic [31:0]    frame_number,
    output logic [31:0]    computed_crc
);
    import idfd_pkg::*;

    logic        valid_reg;
    logic [31:0] crc_reg, exp_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [31:0] frame_reg, ocrc_reg;
    logic        take_out;
    logic [31:0] crc_upd, crc_fin;

    // ARM requests only load the engine, so they never wait on the output slot
    assign cmd_pop  = !cmd_empty && (cmd.kind == CMD_ARM || !valid_reg || pop);
    assign take_out = cmd_pop && cmd.kind != CMD_ARM;
    assign crc_upd  = crc_byte(crc_reg, cmd.data);
    assign crc_fin  = ~crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            crc_reg   <= CrcInit;
            exp_reg   <= '0;
        end
        else
        begin
            if (take_out)
                valid_reg <= 1'b1;
            else if (pop)
                valid_reg <= 1'b0;
            if (cmd_pop)
            begin
                case (cmd.kind)
                    CMD_ARM:
                    begin
                        crc_reg <= CrcInit;
                        exp_reg <= cmd.crc;
                    end
                    CMD_DATA:
                        crc_reg <= crc_upd;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            frame_reg <= cmd.frame;
            if (cmd.kind == CMD_DATA)
            begin
                kind_reg <= KIND_DATA;
                data_reg <= cmd.data;
                last_reg <= cmd.last;
                ocrc_reg <= '0;
            end
            else
            begin
                kind_reg <= (crc_fin == exp_reg) ? KIND_MATCH : KIND_MISMATCH;
                data_reg <= '0;
                last_reg <= 1'b0;
                ocrc_reg <= crc_fin;
            end
        end
    end

    assign empty        = !valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_reg;
    assign last_payload = last_reg;
    assign frame_number = frame_reg;
    assign computed_crc = ocrc_reg;

endmodule

>>> tb/image_frame_deframer_crc_check_test.sv
// Self-checking test of the image frame deframer: line parsing, payload passing and CRC check.
module image_frame_deframer_crc_check_test;
    timeunit 1ns;
    timeprecision 1ps;
    import idfd_pkg::*;

    localparam int StuckLimit = 400000;
    localparam int DrainCycles = 12;
    localparam logic [7:0] NL = 8'h0A;

    // parser phases
    typedef enum logic [1:0] {
        PH_WAIT_JSON, PH_WAIT_HEADER, PH_READ, PH_WAIT_END
    } phase_t;
    typedef enum logic [3:0] {
        NP_IDLE, NP_A_WS, NP_A_SIGN, NP_A_DIG, NP_B_WS, NP_B_SIGN,
        NP_B_ZERO, NP_B_X, NP_B_DIG, NP_DONE
    } num_t;
    localparam logic [2:0] CAND_JSON = 3'd1, CAND_IMAGE = 3'd2, CAND_END = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] frame;
        logic [31:0] crc;
    } deframe_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [7:0] rx_byte = 8'd0;
    logic pop = 1'b0;
    logic full, empty, last_payload;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [31:0] frame_number, computed_crc;

    image_frame_deframer_crc_check uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .rx_byte(rx_byte),
        .pop(pop), .empty(empty), .kind(kind), .data_byte(data_byte),
        .last_payload(last_payload), .frame_number(frame_number),
        .computed_crc(computed_crc)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    phase_t     ph;
    logic [2:0] lpos;
    logic [2:0] cand;
    logic       tail;
    logic [3:0] kpos;
    num_t       np;
    logic       neg_a, neg_b;
    logic [31:0] num_a, num_b, frame_val, exp_len, exp_crc, rcv_cnt, crc_reg;

    deframe_out_t expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int bytes_sent = 0;
    int frames_ended = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    bit long_gaps = 1'b1;

    function automatic bit ws(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int hexv(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] str_at(input string s, input int i);
        return s.getc(i);
    endfunction

    task automatic clear_line();
        lpos = 0; cand = CAND_JSON | CAND_IMAGE | CAND_END; tail = 0; kpos = 0;
        np = NP_IDLE; neg_a = 0; neg_b = 0; num_a = 0; num_b = 0;
    endtask

    task automatic clear_frame();
        ph = PH_WAIT_JSON; exp_len = 0; exp_crc = 0; rcv_cnt = 0; crc_reg = 32'hFFFFFFFF;
    endtask

    task automatic crc_field(input logic [7:0] c);
        int v;
        v = hexv(c);
        case (np)
            NP_B_WS:
                if (!ws(c))
                begin
                    if (c == "+" || c == "-")
                    begin
                        neg_b = (c == "-"); np = NP_B_SIGN;
                    end
                    else if (c == "0") np = NP_B_ZERO;
                    else if (v >= 0)
                    begin
                        num_b = v; np = NP_B_DIG;
                    end
                    else np = NP_DONE;
                end
            NP_B_SIGN, NP_B_ZERO, NP_B_X:
                if (np == NP_B_SIGN && c == "0") np = NP_B_ZERO;
                else if (np == NP_B_ZERO && (c == "x" || c == "X")) np = NP_B_X;
                else if (v >= 0)
                begin
                    num_b = v; np = NP_B_DIG;
                end
                else np = NP_DONE;
            NP_B_DIG:
                if (v >= 0) num_b = {num_b[27:0], 4'(v)};
                else np = NP_DONE;
            default: ;
        endcase
    endtask

    // first number field, shared by the frame key value and the header length
    task automatic dec_field(input logic [7:0] c, input bit header);
        case (np)
            NP_A_WS:
                if (!ws(c))
                begin
                    if (c == "+" || c == "-")
                    begin
                        neg_a = (c == "-"); np = NP_A_SIGN;
                    end
                    else if (dec(c))
                    begin
                        num_a = c - "0"; np = NP_A_DIG;
                    end
                    else np = NP_DONE;
                end
            NP_A_SIGN:
                if (dec(c))
                begin
                    num_a = c - "0"; np = NP_A_DIG;
                end
                else np = NP_DONE;
            NP_A_DIG:
                if (dec(c)) num_a = num_a * 10 + (c - "0");
                else if (header)
                begin
                    np = NP_B_WS; crc_field(c);
                end
                else np = NP_DONE;
            default:
                if (header) crc_field(c);
        endcase
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [2:0] p;
        p = lpos;
        if (p == 0 && ws(c)) return;
        if (p < 5 && c != str_at("JSON ", p)) cand &= ~CAND_JSON;
        if (p < 6 && c != str_at("IMAGE ", p)) cand &= ~CAND_IMAGE;
        if (p < 3)
        begin
            if (c != str_at("END", p)) cand &= ~CAND_END;
        end
        else if (!ws(c)) cand &= ~CAND_END;
        if ((cand & CAND_JSON) != 0 && p >= 5)
        begin
            if (!ws(c)) tail = 1;
            if (kpos < 8)
            begin
                if (c == str_at("\"frame\":", kpos)) kpos++;
                else kpos = (c == 8'h22) ? 1 : 0;
                if (kpos == 8) np = NP_A_WS;
            end
            else dec_field(c, 0);
        end
        if ((cand & CAND_IMAGE) != 0 && p >= 6)
        begin
            if (!ws(c)) tail = 1;
            dec_field(c, 1);
        end
        if ((cand & CAND_IMAGE) != 0 && p == 5) np = NP_A_WS;
        if (p < 7) lpos = p + 1;
    endtask

    task automatic predict_byte(input logic [7:0] c);
        deframe_out_t r;
        logic [31:0] need;
        if (ph == PH_READ)
        begin
            crc_reg ^= {24'd0, c};
            for (int i = 0; i < 8; i++)
                crc_reg = (crc_reg >> 1) ^ (crc_reg[0] ? 32'hEDB88320 : 32'd0);
            rcv_cnt++;
            need = (exp_len == 0) ? 1 : exp_len;
            r = '{KIND_DATA, c, rcv_cnt >= need, frame_val, 32'd0};
            if (rcv_cnt >= need) ph = PH_WAIT_END;
            expected_q.push_back(r);
            return;
        end
        if (c != NL)
        begin
            parse_char(c);
            return;
        end
        if ((cand & CAND_JSON) != 0 && tail)
        begin
            clear_frame();
            if (kpos == 8) frame_val = neg_a ? -num_a : num_a;
            ph = PH_WAIT_HEADER;
        end
        else if (ph == PH_WAIT_HEADER && (cand & CAND_IMAGE) != 0 && tail)
        begin
            exp_len = neg_a ? -num_a : num_a;
            exp_crc = neg_b ? -num_b : num_b;
            rcv_cnt = 0; crc_reg = 32'hFFFFFFFF; ph = PH_READ;
        end
        else if (ph == PH_WAIT_END && (cand & CAND_END) != 0 && lpos >= 3)
        begin
            r = '{(~crc_reg == exp_crc) ? KIND_MATCH : KIND_MISMATCH, 8'd0, 1'b0,
                  frame_val, ~crc_reg};
            expected_q.push_back(r);
            frames_ended++;
            clear_frame();
        end
        clear_line();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 99) < 60) ? 0 :
               ($urandom_range(0, 19) == 0 && long_gaps) ? $urandom_range(10, 40) :
               $urandom_range(1, 3);
    endfunction

    // offer one byte, wait until taken
    task automatic send_byte(input logic [7:0] c);
        int g;
        push <= 1'b1;
        rx_byte <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_byte(c);
        bytes_sent++;
        if ($urandom_range(0, 3) == 0)
        begin
            g = gap_len();
            if (g > 0)
            begin
                push <= 1'b0;
                rx_byte <= 8'($urandom);
                repeat (g) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(str_at(s, i));
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(NL);
    endtask

    // payload of n bytes, any values including newline
    task automatic send_payload(input int n, output logic [31:0] crc);
        logic [7:0] b;
        crc = 32'hFFFFFFFF;
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 9) == 0) ? NL : 8'($urandom);
            crc ^= {24'd0, b};
            for (int k = 0; k < 8; k++) crc = (crc >> 1) ^ (crc[0] ? 32'hEDB88320 : 32'd0);
            send_byte(b);
        end
        crc = ~crc;
    endtask

    task automatic send_frame(input int fnum, input int len, input bit good);
        logic [31:0] crc;
        send_line($sformatf("JSON {\"frame\":%0d}", fnum));
        // predict the crc ahead by building header after payload is unknown: use
        // a two-pass trick - compute over random bytes chosen now
        begin
            logic [7:0] pl[$];
            logic [31:0] c;
            c = 32'hFFFFFFFF;
            for (int i = 0; i < (len == 0 ? 1 : len); i++)
            begin
                pl.push_back(($urandom_range(0, 9) == 0) ? NL : 8'($urandom));
                c ^= {24'd0, pl[i]};
                for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
            end
            c = ~c;
            if (!good) c ^= 32'(1) << $urandom_range(0, 31);
            send_line($sformatf("IMAGE %0d %h", len, c));
            foreach (pl[i]) send_byte(pl[i]);
        end
        send_line("END");
    endtask

    always @(posedge clk)
    begin
        deframe_out_t got, want;
        cycle_count++;
        if (cycle_count > StuckLimit)
        begin
            $display("timeout");
            $display("image_frame_deframer_crc_check: mismatch");
            $finish;
        end
        if (rst_n && pop && !empty)
        begin
            got = '{kind, data_byte, last_payload, frame_number, computed_crc};
            results_seen++;
            if (expected_q.size() == 0) report("unexpected result kind", kind, 0);
            else
            begin
                want = expected_q.pop_front();
                if (got.kind != want.kind) report("kind", got.kind, want.kind);
                if (got.data != want.data) report("data_byte", got.data, want.data);
                if (got.last != want.last) report("last_payload", got.last, want.last);
                if (got.frame != want.frame) report("frame_number", got.frame, want.frame);
                if (got.crc != want.crc) report("computed_crc", got.crc, want.crc);
            end
        end
    end

    // result side: random pop while long gaps are on, else pop held high, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else if (long_gaps)
            pop <= ($urandom_range(0, 99) < 70);
        else
            pop <= 1'b1;
    end

    task automatic test_directed();
        send_line("JSON {\"frame\":7}");
        send_line("IMAGE 3 0x0");
        send_text("\n\n\n");
        send_line("END");
        send_frame(0, 0, 1);
        send_frame(-5, 2, 0);
        send_line("  JSON   ");
        send_line("JSON x");
        send_line("IMAGE");
        send_line("IMAGE +2 -0XFFffFFFF");
        send_byte(8'h00); send_byte(8'hFF);
        send_line(" \t END \r");
        send_line("JSON \"fr\"frame\": -4294967295 z");
        send_line("IMAGE abc");
        send_byte(8'h80);
        send_line("ENDX");
        send_line("END");
        send_line("END");
        send_line("JSON {\"frame\":99999999999}");
        send_line("IMAGE 1 ");
        send_byte(NL);
        send_line("END");
    endtask

    task automatic test_random_frames(input int target);
        int n;
        while (bytes_sent < target)
        begin
            n = $urandom_range(0, 9);
            if (n < 7)
                send_frame($urandom, ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                           : $urandom_range(0, 8), $urandom_range(0, 3) != 0);
            else if (n == 7)
            begin
                repeat ($urandom_range(1, 12))
                    send_byte(($urandom_range(0, 2) == 0) ? NL : 8'($urandom));
            end
            else if (n == 8)
                send_line($sformatf("IMAGE %0d %0h", $urandom_range(0, 3), $urandom));
            else
                send_line(($urandom_range(0, 1) != 0) ? "END" : "JSON frame");
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        send_frame(12, 40, 1);
        if (hold_cycles > 0)
        begin
            push <= 1'b0;
            while (hold_cycles > 0) @(posedge clk);
        end
    endtask

    initial
    begin
        clear_line();
        clear_frame();
        frame_val = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_frames(900);
        long_gaps = 1'b0;
        test_random_frames(1300);
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        $display("covered %0d bytes, %0d results, %0d frame ends incl. CRC mismatches",
                 bytes_sent, results_seen, frames_ended);
        if (errors == 0)
            $display("image_frame_deframer_crc_check: match");
        else
            $display("image_frame_deframer_crc_check: mismatch");
        $finish;
    end
endmodule
